// ===== sv/sgbs_pkg.sv =====
`timescale 1ns / 1ps

package sgbs_pkg;

	// Field widths of the request and result
	localparam int VAL_W      = 32;
	localparam int ANGLE_W    = 32;
	localparam int ROW_IN_W   = 7;
	localparam int COL_IN_W   = 7;
	localparam int CFG_DATA_W = 8;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_COLS_W = 8;
	localparam int CFG_ROWS_W = 7;

	// Angle format: one turn is 2^TURN_BITS units
	localparam int TURN_BITS = 20;
	localparam int WEIGHT_W  = 16;
	localparam logic [TURN_BITS-1:0] HALF_TURN = TURN_BITS'(1 << (TURN_BITS - 1));

	// Configuration register indexes and reset values
	localparam logic [CFG_IDX_W-1:0] REG_COLUMNS  = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LAST_ROW = 2'd1;
	localparam logic [CFG_COLS_W-1:0] COLS_RESET = 8'd64;
	localparam logic [CFG_ROWS_W-1:0] ROWS_RESET = 7'd32;
	localparam int COLS_MIN = 2;
	localparam int ROWS_MIN = 1;

	// Grid read selects (row, column corner)
	localparam logic [1:0] RD_LO_LO = 2'd0;
	localparam logic [1:0] RD_LO_HI = 2'd1;
	localparam logic [1:0] RD_HI_LO = 2'd2;
	localparam logic [1:0] RD_HI_HI = 2'd3;

	// Read data capture slots
	localparam logic [1:0] CAP_D0 = 2'd0;
	localparam logic [1:0] CAP_D1 = 2'd1;
	localparam logic [1:0] CAP_D2 = 2'd2;

	// Blend operand sets
	localparam logic [1:0] BLEND_LOWER = 2'd0;
	localparam logic [1:0] BLEND_UPPER = 2'd1;
	localparam logic [1:0] BLEND_FINAL = 2'd2;

	// Blend result destinations
	localparam logic [1:0] DST_LOWER  = 2'd0;
	localparam logic [1:0] DST_UPPER  = 2'd1;
	localparam logic [1:0] DST_RESULT = 2'd2;

	typedef struct packed {
		logic       load_in;
		logic       scale;
		logic       index;
		logic       rd;
		logic [1:0] rd_sel;
		logic       cap;
		logic [1:0] cap_sel;
		logic       blend_a;
		logic [1:0] a_sel;
		logic       blend_b;
		logic [1:0] b_dst;
		logic       load_out;
	} sgbs_cmd_t;

endpackage

// ===== sv/sgbs_ram.sv =====
`timescale 1ns / 1ps

module sgbs_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 8320
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[addr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== sv/sgbs_datapath.sv =====
`timescale 1ns / 1ps

module sgbs_datapath import sgbs_pkg::*; #(
	parameter int MAX_COLUMNS   = 128,
	parameter int MAX_ROW_INDEX = 64
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  sgbs_cmd_t                    cmd,
	input  logic                         mode,
	input  logic [ROW_IN_W-1:0]          grid_row,
	input  logic [COL_IN_W-1:0]          grid_col,
	input  logic signed [VAL_W-1:0]      grid_value,
	input  logic signed [ANGLE_W-1:0]    sample_phi,
	input  logic signed [ANGLE_W-1:0]    sample_theta,
	input  logic                         cfg_we,
	input  logic [CFG_IDX_W-1:0]         cfg_index,
	input  logic [CFG_DATA_W-1:0]        cfg_data,
	output logic signed [VAL_W-1:0]      sampled_value,
	output logic                         pole_crossed,
	output logic                         is_sample
);

	localparam int COL_AW = $clog2(MAX_COLUMNS);
	localparam int ROW_W  = $clog2(MAX_ROW_INDEX + 1);
	localparam int CW     = $clog2(MAX_COLUMNS + 1);
	localparam int ADDR_W = ROW_W + COL_AW;
	localparam int DEPTH  = (MAX_ROW_INDEX + 1) * (1 << COL_AW);
	localparam int PROD_W = TURN_BITS + CW;
	localparam int MUL_W  = VAL_W + 1 + WEIGHT_W + 1;

	// Configuration
	logic [CFG_COLS_W-1:0] cols_cfg_q;
	logic [CFG_ROWS_W-1:0] last_cfg_q;
	logic [31:0]           cols_ext, last_ext;
	logic [CW-1:0]         cols_eff;
	logic [ROW_W-1:0]      last_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cols_cfg_q <= COLS_RESET;
			last_cfg_q <= ROWS_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_COLUMNS:  cols_cfg_q <= CFG_COLS_W'(cfg_data);
				REG_LAST_ROW: last_cfg_q <= CFG_ROWS_W'(cfg_data);
				default: ;
			endcase
		end
	end

	always_comb begin
		cols_ext = 32'(cols_cfg_q);
		last_ext = 32'(last_cfg_q);
		if (cols_ext < 32'(COLS_MIN)) begin
			cols_eff = CW'(COLS_MIN);
		end else if (cols_ext > 32'(MAX_COLUMNS)) begin
			cols_eff = CW'(MAX_COLUMNS);
		end else begin
			cols_eff = CW'(cols_ext);
		end
		if (last_ext < 32'(ROWS_MIN)) begin
			last_eff = ROW_W'(ROWS_MIN);
		end else if (last_ext > 32'(MAX_ROW_INDEX)) begin
			last_eff = ROW_W'(MAX_ROW_INDEX);
		end else begin
			last_eff = ROW_W'(last_ext);
		end
	end

	// Request latch: only the low turn bits of each angle matter
	logic [TURN_BITS-1:0] phi_q, theta_q;
	logic                 smp_q;

	always_ff @(posedge clk) begin
		if (cmd.load_in) begin
			phi_q   <= sample_phi[TURN_BITS-1:0];
			theta_q <= sample_theta[TURN_BITS-1:0];
			smp_q   <= mode;
		end
	end

	// Fold across the south pole and scale by the column count
	logic                 flip;
	logic [TURN_BITS-1:0] theta_f, phi_f;
	logic [PROD_W-1:0]    nphi_q, ntheta_q;
	logic                 flip_q;

	always_comb begin
		flip    = theta_q > HALF_TURN;
		theta_f = flip ? (~theta_q + TURN_BITS'(1)) : theta_q;
		phi_f   = flip ? (phi_q ^ HALF_TURN) : phi_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			nphi_q   <= PROD_W'(phi_f) * PROD_W'(cols_eff);
			ntheta_q <= PROD_W'(theta_f) * PROD_W'(cols_eff);
			flip_q   <= flip;
		end
	end

	// Neighbor indices and weights
	logic [COL_AW-1:0]   phi_idx, theta_idx;
	logic [31:0]         t_ext;
	logic [COL_AW-1:0]   c_lo_q, c_hi_q;
	logic [ROW_W-1:0]    r_lo_q, r_hi_q;
	logic [WEIGHT_W-1:0] w_phi_q, w_theta_q;

	assign phi_idx   = nphi_q[TURN_BITS +: COL_AW];
	assign theta_idx = ntheta_q[TURN_BITS +: COL_AW];
	assign t_ext     = 32'(theta_idx);

	always_ff @(posedge clk) begin
		if (cmd.index) begin
			c_lo_q    <= phi_idx;
			c_hi_q    <= (32'(phi_idx) + 32'd1 == 32'(cols_eff)) ? '0
				: COL_AW'(32'(phi_idx) + 32'd1);
			r_lo_q    <= (t_ext > 32'(last_eff)) ? last_eff : ROW_W'(t_ext);
			r_hi_q    <= (t_ext + 32'd1 > 32'(last_eff)) ? last_eff
				: ROW_W'(t_ext + 32'd1);
			w_phi_q   <= nphi_q[TURN_BITS-1 -: WEIGHT_W];
			w_theta_q <= ntheta_q[TURN_BITS-1 -: WEIGHT_W];
		end
	end

	// Grid store: write from the request ports, read the four corners in turn
	logic              wr_ok, ram_we;
	logic [ADDR_W-1:0] ram_addr;
	logic [VAL_W-1:0]  ram_rdata;

	assign wr_ok  = (32'(grid_row) <= 32'(MAX_ROW_INDEX)) && (32'(grid_col) < 32'(MAX_COLUMNS));
	assign ram_we = cmd.load_in && !mode && wr_ok;

	always_comb begin
		if (cmd.rd) begin
			unique case (cmd.rd_sel)
				RD_LO_LO: ram_addr = {r_lo_q, c_lo_q};
				RD_LO_HI: ram_addr = {r_lo_q, c_hi_q};
				RD_HI_LO: ram_addr = {r_hi_q, c_lo_q};
				RD_HI_HI: ram_addr = {r_hi_q, c_hi_q};
				default:  ram_addr = {r_lo_q, c_lo_q};
			endcase
		end else begin
			ram_addr = {ROW_W'(grid_row), COL_AW'(grid_col)};
		end
	end

	sgbs_ram #(
		.WIDTH(VAL_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.re   (cmd.rd),
		.addr (ram_addr),
		.wdata(grid_value),
		.rdata(ram_rdata)
	);

	logic signed [VAL_W-1:0] d0_q, d1_q, d2_q;

	always_ff @(posedge clk) begin
		if (cmd.cap) begin
			case (cmd.cap_sel)
				CAP_D0:  d0_q <= ram_rdata;
				CAP_D1:  d1_q <= ram_rdata;
				CAP_D2:  d2_q <= ram_rdata;
				default: ;
			endcase
		end
	end

	// Shared blend unit: x + floor((y - x) * w / 2^16), two stages
	logic signed [VAL_W-1:0] ax, ay;
	logic [WEIGHT_W-1:0]     aw;
	logic signed [VAL_W-1:0] bx_q;
	logic signed [VAL_W:0]   bd_q;
	logic [WEIGHT_W-1:0]     bw_q;
	logic signed [MUL_W-1:0] prod;
	logic signed [VAL_W-1:0] blend_out;
	logic signed [VAL_W-1:0] lower_q, upper_q, res_q;

	always_comb begin
		case (cmd.a_sel)
			BLEND_LOWER: begin
				ax = d0_q;
				ay = d1_q;
				aw = w_phi_q;
			end
			BLEND_UPPER: begin
				ax = d2_q;
				ay = ram_rdata;
				aw = w_phi_q;
			end
			BLEND_FINAL: begin
				ax = lower_q;
				ay = upper_q;
				aw = w_theta_q;
			end
			default: begin
				ax = d0_q;
				ay = d1_q;
				aw = w_phi_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.blend_a) begin
			bx_q <= ax;
			bd_q <= $signed({ay[VAL_W-1], ay}) - $signed({ax[VAL_W-1], ax});
			bw_q <= aw;
		end
	end

	assign prod      = bd_q * $signed({1'b0, bw_q});
	assign blend_out = bx_q + prod[VAL_W+WEIGHT_W-1:WEIGHT_W];

	always_ff @(posedge clk) begin
		if (cmd.blend_b) begin
			case (cmd.b_dst)
				DST_LOWER:  lower_q <= blend_out;
				DST_UPPER:  upper_q <= blend_out;
				DST_RESULT: res_q   <= blend_out;
				default: ;
			endcase
		end
	end

	// Output register
	logic signed [VAL_W-1:0] value_q;
	logic                    pole_q, smp_out_q;

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			value_q   <= smp_q ? res_q : '0;
			pole_q    <= smp_q && flip_q;
			smp_out_q <= smp_q;
		end
	end

	assign sampled_value = value_q;
	assign pole_crossed  = pole_q;
	assign is_sample     = smp_out_q;

endmodule

// ===== sv/sgbs_ctrl.sv =====
`timescale 1ns / 1ps

module sgbs_ctrl import sgbs_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      in_valid,
	input  logic      mode,
	output logic      in_ready,
	output logic      out_valid,
	input  logic      out_ready,
	output sgbs_cmd_t cmd
);

	localparam logic [3:0] S_IDLE  = 4'd0;
	localparam logic [3:0] S_SCALE = 4'd1;
	localparam logic [3:0] S_INDEX = 4'd2;
	localparam logic [3:0] S_RD0   = 4'd3;
	localparam logic [3:0] S_RD1   = 4'd4;
	localparam logic [3:0] S_RD2   = 4'd5;
	localparam logic [3:0] S_RD3   = 4'd6;
	localparam logic [3:0] S_BLD0  = 4'd7;
	localparam logic [3:0] S_BLD1  = 4'd8;
	localparam logic [3:0] S_BLD2  = 4'd9;
	localparam logic [3:0] S_BLD3  = 4'd10;
	localparam logic [3:0] S_DONE  = 4'd11;

	logic [3:0] state_q, state_d;
	logic       out_valid_q;
	logic       accept, out_free;

	assign in_ready = (state_q == S_IDLE);
	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd.load_in = 1'b1;
					state_d     = mode ? S_SCALE : S_DONE;
				end
			end
			S_SCALE: begin
				cmd.scale = 1'b1;
				state_d   = S_INDEX;
			end
			S_INDEX: begin
				cmd.index = 1'b1;
				state_d   = S_RD0;
			end
			S_RD0: begin
				cmd.rd     = 1'b1;
				cmd.rd_sel = RD_LO_LO;
				state_d    = S_RD1;
			end
			S_RD1: begin
				cmd.rd      = 1'b1;
				cmd.rd_sel  = RD_LO_HI;
				cmd.cap     = 1'b1;
				cmd.cap_sel = CAP_D0;
				state_d     = S_RD2;
			end
			S_RD2: begin
				cmd.rd      = 1'b1;
				cmd.rd_sel  = RD_HI_LO;
				cmd.cap     = 1'b1;
				cmd.cap_sel = CAP_D1;
				state_d     = S_RD3;
			end
			S_RD3: begin
				cmd.rd      = 1'b1;
				cmd.rd_sel  = RD_HI_HI;
				cmd.cap     = 1'b1;
				cmd.cap_sel = CAP_D2;
				cmd.blend_a = 1'b1;
				cmd.a_sel   = BLEND_LOWER;
				state_d     = S_BLD0;
			end
			S_BLD0: begin
				cmd.blend_a = 1'b1;
				cmd.a_sel   = BLEND_UPPER;
				cmd.blend_b = 1'b1;
				cmd.b_dst   = DST_LOWER;
				state_d     = S_BLD1;
			end
			S_BLD1: begin
				cmd.blend_b = 1'b1;
				cmd.b_dst   = DST_UPPER;
				state_d     = S_BLD2;
			end
			S_BLD2: begin
				cmd.blend_a = 1'b1;
				cmd.a_sel   = BLEND_FINAL;
				state_d     = S_BLD3;
			end
			S_BLD3: begin
				cmd.blend_b = 1'b1;
				cmd.b_dst   = DST_RESULT;
				state_d     = S_DONE;
			end
			S_DONE: begin
				// hold the result until the output slot is free
				if (out_free) begin
					cmd.load_out = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;

`ifndef NO_ASSERTIONS
	a_sample_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && mode) |-> ##11 (state_q == S_DONE))
		else $error("sample request did not reach completion on schedule");

	a_write_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && !mode) |=> (state_q == S_DONE))
		else $error("write request did not complete in one cycle");

	a_valid_from_done: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_DONE))
		else $error("result raised outside completion state");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DONE && out_valid_q && !out_ready) |=> (state_q == S_DONE))
		else $error("pending result overwritten");
`endif

endmodule

// ===== sv/spherical_grid_bilinear_sampler_core.sv =====
`timescale 1ns / 1ps

// Bilinear sampler over a latitude-longitude grid of signed Q16.16 values.
// A request with mode 0 stores grid_value at (grid_row, grid_col); entries
// outside the grid are dropped but still acknowledged with a zero result.
// A request with mode 1 samples the grid at (sample_phi, sample_theta),
// angles in turns with 2^20 units per turn: the polar angle is folded back
// past the south pole (pole_crossed marks it, and the azimuth advances by half
// a turn), both angles are scaled by columns_in_use, and the four neighbors
// are blended with 16-bit weights, azimuth first, columns wrapping and rows
// saturating at last_row_index. Only entries that were written may be read.
// Timing: a sample is paced by the single port of the grid store (four
// reads, one per cycle) and the shared two-stage blend unit that runs three
// times; a write skips both. One request is in work at a time; a finished
// result waits in the output register so the next request can be accepted
// while it is unread. The store needs no clearing pass after reset.
// Configuration writes are always accepted (cfg_ready is tied high) and
// must be issued only while the block is idle.
module spherical_grid_bilinear_sampler_core import sgbs_pkg::*; #(
	parameter int MAX_COLUMNS   = 128,
	parameter int MAX_ROW_INDEX = 64
) (
	input  logic                      clk,
	input  logic                      arst_n,

	// Request channel
	input  logic                      in_valid,
	output logic                      in_ready,
	input  logic                      mode,
	input  logic [ROW_IN_W-1:0]       grid_row,
	input  logic [COL_IN_W-1:0]       grid_col,
	input  logic signed [VAL_W-1:0]   grid_value,
	input  logic signed [ANGLE_W-1:0] sample_phi,
	input  logic signed [ANGLE_W-1:0] sample_theta,

	// Result channel
	output logic                      out_valid,
	input  logic                      out_ready,
	output logic signed [VAL_W-1:0]   sampled_value,
	output logic                      pole_crossed,
	output logic                      is_sample,

	// Configuration write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic [CFG_IDX_W-1:0]      cfg_index,
	input  logic [CFG_DATA_W-1:0]     cfg_data
);

	sgbs_cmd_t cmd;

	// Registers live in the datapath; a write lands on every cfg_valid.
	assign cfg_ready = 1'b1;

	// Sequence each request: latch, then for a sample scale, index, four reads, three blends.
	sgbs_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.mode     (mode),
		.in_ready (in_ready),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.cmd      (cmd)
	);

	// Angle folding, index math, grid store, blend unit and output register.
	sgbs_datapath #(
		.MAX_COLUMNS  (MAX_COLUMNS),
		.MAX_ROW_INDEX(MAX_ROW_INDEX)
	) u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.mode         (mode),
		.grid_row     (grid_row),
		.grid_col     (grid_col),
		.grid_value   (grid_value),
		.sample_phi   (sample_phi),
		.sample_theta (sample_theta),
		.cfg_we       (cfg_valid),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.sampled_value(sampled_value),
		.pole_crossed (pole_crossed),
		.is_sample    (is_sample)
	);

endmodule

// ===== bench/spherical_grid_bilinear_sampler_core_tb.sv =====
`timescale 1ns / 1ps

module spherical_grid_bilinear_sampler_core_tb;
	import sgbs_pkg::*;

	localparam int GRID_COLUMNS  = 128;
	localparam int GRID_LAST_ROW = 64;
	localparam int GRID_DEPTH    = (GRID_LAST_ROW + 1) * GRID_COLUMNS;

	localparam logic MODE_WRITE  = 1'b0;
	localparam logic MODE_SAMPLE = 1'b1;

	// Indexes past the register list; the block must ignore writes to them
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 2'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 2'd3;

	localparam int IDLE_MAX     = 18;
	localparam int HOLD_CYCLES  = 300;
	localparam int PHASES       = 10;
	localparam int HOLD_PHASE   = 3;
	localparam int TAIL_CYCLES  = 24;

	// Per-phase register values (some beyond the legal range), request counts and idling.
	// Most phases keep the grid small so that it fills quickly.
	int phase_cols  [PHASES] = '{8, 2, 0, 5, 255, 128, 16, 1, 64, 3};
	int phase_rows  [PHASES] = '{4, 1, 0, 3, 127, 65, 8, 255, 32, 64};
	int phase_count [PHASES] = '{50, 30, 20, 40, 16, 12, 40, 30, 16, 40};
	int phase_gap   [PHASES] = '{IDLE_MAX, 0, IDLE_MAX, 0, IDLE_MAX, 5, IDLE_MAX, IDLE_MAX, 6,
		IDLE_MAX};
	int phase_stall [PHASES] = '{IDLE_MAX, 0, 0, IDLE_MAX, IDLE_MAX, 5, IDLE_MAX, 0, IDLE_MAX,
		IDLE_MAX};

	typedef struct {
		logic                      mode;
		logic [ROW_IN_W-1:0]       row;
		logic [COL_IN_W-1:0]       col;
		logic signed [VAL_W-1:0]   value;
		logic signed [ANGLE_W-1:0] phi;
		logic signed [ANGLE_W-1:0] theta;
	} grid_request_t;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    reflected;
		logic                    is_sample;
	} grid_result_t;

	// Where a sample point lands: the four neighbors and the two blend weights
	typedef struct {
		int unsigned          row_lo;
		int unsigned          row_hi;
		int unsigned          col_lo;
		int unsigned          col_hi;
		logic [WEIGHT_W-1:0]  w_phi;
		logic [WEIGHT_W-1:0]  w_theta;
		logic                 reflected;
	} sample_geometry_t;

	logic                      clk;
	logic                      arst_n;
	logic                      in_valid;
	logic                      in_ready;
	logic                      mode;
	logic [ROW_IN_W-1:0]       grid_row;
	logic [COL_IN_W-1:0]       grid_col;
	logic signed [VAL_W-1:0]   grid_value;
	logic signed [ANGLE_W-1:0] sample_phi;
	logic signed [ANGLE_W-1:0] sample_theta;
	logic                      out_valid;
	logic                      out_ready;
	logic signed [VAL_W-1:0]   sampled_value;
	logic                      pole_crossed;
	logic                      is_sample;
	logic                      cfg_valid;
	logic                      cfg_ready;
	logic [CFG_IDX_W-1:0]      cfg_index;
	logic [CFG_DATA_W-1:0]     cfg_data;

	// Mirror of the block: grid contents and register values
	logic signed [VAL_W-1:0] grid_model [GRID_DEPTH];
	logic [CFG_COLS_W-1:0]   columns_setting;
	logic [CFG_ROWS_W-1:0]   last_row_setting;

	// Entries already covered by a queued write; samples only touch these
	bit written_mask [GRID_DEPTH];

	grid_request_t pending_reqs[$];
	grid_result_t  expected_results[$];
	grid_request_t offered_req;
	grid_result_t  oldest;

	// reqs_queued belongs to the stimulus process, results_seen to the monitor
	int  reqs_queued;
	int  results_seen;
	int  error_count;
	int  samples_checked;
	int  poles_seen;
	int  writes_acked;
	int  config_writes;

	// Idling knobs, set by the stimulus process between phases
	int  gap_max;
	int  stall_max;
	int  gap_left;
	int  stall_left;
	int  hold_order;
	int  hold_left;
	logic req_taken;
	logic res_taken;

	spherical_grid_bilinear_sampler_core #(
		.MAX_COLUMNS(GRID_COLUMNS),
		.MAX_ROW_INDEX(GRID_LAST_ROW)
	) DUT (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.mode(mode),
		.grid_row(grid_row),
		.grid_col(grid_col),
		.grid_value(grid_value),
		.sample_phi(sample_phi),
		.sample_theta(sample_theta),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.sampled_value(sampled_value),
		.pole_crossed(pole_crossed),
		.is_sample(is_sample),
		.cfg_valid(cfg_valid),
		.cfg_ready(cfg_ready),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------

	// Register values as the block applies them: clamp into the legal range
	function automatic int unsigned cols_in_effect();
		if (columns_setting < COLS_MIN)
			return COLS_MIN;
		if (columns_setting > GRID_COLUMNS)
			return GRID_COLUMNS;
		return 32'(columns_setting);
	endfunction

	function automatic int unsigned last_row_in_effect();
		if (last_row_setting < ROWS_MIN)
			return ROWS_MIN;
		if (last_row_setting > GRID_LAST_ROW)
			return GRID_LAST_ROW;
		return 32'(last_row_setting);
	endfunction

	function automatic sample_geometry_t locate_sample(logic [ANGLE_W-1:0] phi_in,
			logic [ANGLE_W-1:0] theta_in);
		sample_geometry_t   g;
		int unsigned        cols;
		int unsigned        last_row;
		int unsigned        phi_idx;
		int unsigned        theta_idx;
		logic [ANGLE_W-1:0] phi;
		logic [TURN_BITS-1:0] theta;
		logic [63:0]        nphi;
		logic [63:0]        ntheta;
		cols = cols_in_effect();
		last_row = last_row_in_effect();
		theta = theta_in[TURN_BITS-1:0];
		phi = phi_in;
		g.reflected = 1'b0;
		// Past the south pole: fold the polar angle back and swing the azimuth half a turn.
		// Exactly half a turn stays put.
		if (theta > HALF_TURN) begin
			theta = -theta;
			phi = phi + ANGLE_W'(HALF_TURN);
			g.reflected = 1'b1;
		end
		nphi = 64'(phi[TURN_BITS-1:0]) * 64'(cols);
		ntheta = 64'(theta) * 64'(cols);
		phi_idx = 32'(nphi >> TURN_BITS);
		theta_idx = 32'(ntheta >> TURN_BITS);
		g.w_phi = nphi[TURN_BITS-1:TURN_BITS-WEIGHT_W];
		g.w_theta = ntheta[TURN_BITS-1:TURN_BITS-WEIGHT_W];
		// Columns wrap around the azimuth, rows saturate at the last row
		g.col_lo = phi_idx % cols;
		g.col_hi = (g.col_lo + 1) % cols;
		g.row_lo = (theta_idx > last_row) ? last_row : theta_idx;
		g.row_hi = (theta_idx + 1 > last_row) ? last_row : theta_idx + 1;
		return g;
	endfunction

	// floor((a*(1-w) + b*w)), weights in 1/65536 units
	function automatic logic signed [VAL_W-1:0] weigh_pair(logic signed [VAL_W-1:0] a,
			logic signed [VAL_W-1:0] b, logic [WEIGHT_W-1:0] w);
		longint sum;
		sum = longint'(a) * (longint'(1 << WEIGHT_W) - longint'(w)) + longint'(b) * longint'(w);
		return VAL_W'(sum >>> WEIGHT_W);
	endfunction

	// Apply one accepted request to the mirror and return the result it must produce
	function automatic grid_result_t model_request(grid_request_t r);
		grid_result_t            e;
		sample_geometry_t        g;
		logic signed [VAL_W-1:0] lower;
		logic signed [VAL_W-1:0] upper;
		e.value = '0;
		e.reflected = 1'b0;
		e.is_sample = 1'b0;
		if (r.mode == MODE_WRITE) begin
			// Out-of-grid rows are dropped but still acknowledged
			if (r.row <= GRID_LAST_ROW && r.col < GRID_COLUMNS)
				grid_model[r.row * GRID_COLUMNS + r.col] = r.value;
			return e;
		end
		g = locate_sample(r.phi, r.theta);
		lower = weigh_pair(grid_model[g.row_lo * GRID_COLUMNS + g.col_lo],
			grid_model[g.row_lo * GRID_COLUMNS + g.col_hi], g.w_phi);
		upper = weigh_pair(grid_model[g.row_hi * GRID_COLUMNS + g.col_lo],
			grid_model[g.row_hi * GRID_COLUMNS + g.col_hi], g.w_phi);
		e.value = weigh_pair(lower, upper, g.w_theta);
		e.reflected = g.reflected;
		e.is_sample = 1'b1;
		return e;
	endfunction

	// ------------------------------------------------------------------
	// Stimulus generation
	// ------------------------------------------------------------------

	function automatic void queue_request(grid_request_t r);
		pending_reqs.push_back(r);
		reqs_queued++;
	endfunction

	function automatic void queue_write(int unsigned row, int unsigned col,
			logic [VAL_W-1:0] value);
		grid_request_t r;
		r.mode = MODE_WRITE;
		r.row = ROW_IN_W'(row);
		r.col = COL_IN_W'(col);
		r.value = value;
		// Angles are don't-care for a write; toggle them anyway
		r.phi = $urandom;
		r.theta = $urandom;
		if (row <= GRID_LAST_ROW && col < GRID_COLUMNS)
			written_mask[row * GRID_COLUMNS + col] = 1'b1;
		queue_request(r);
	endfunction

	// Fill a neighbor with a random value unless some earlier request already wrote it
	function automatic void cover_entry(int unsigned row, int unsigned col);
		if (!written_mask[row * GRID_COLUMNS + col])
			queue_write(row, col, $urandom);
	endfunction

	function automatic void queue_sample(logic [ANGLE_W-1:0] phi, logic [ANGLE_W-1:0] theta);
		grid_request_t    r;
		sample_geometry_t g;
		g = locate_sample(phi, theta);
		cover_entry(g.row_lo, g.col_lo);
		cover_entry(g.row_lo, g.col_hi);
		cover_entry(g.row_hi, g.col_lo);
		cover_entry(g.row_hi, g.col_hi);
		r.mode = MODE_SAMPLE;
		r.row = ROW_IN_W'($urandom_range(0, 127));
		r.col = COL_IN_W'($urandom_range(0, 127));
		r.value = $urandom;
		r.phi = phi;
		r.theta = theta;
		queue_request(r);
	endfunction

	function automatic void queue_random_write();
		if ($urandom_range(0, 1))
			queue_write($urandom_range(0, last_row_in_effect()),
				$urandom_range(0, cols_in_effect() - 1), $urandom);
		else
			queue_write($urandom_range(0, 127), $urandom_range(0, 127), $urandom);
	endfunction

	// Random point; the polar angle leans toward the poles and the half-turn fold
	function automatic void queue_random_sample();
		logic [ANGLE_W-1:0] theta;
		theta = $urandom;
		case ($urandom_range(0, 3))
			0: theta[TURN_BITS-1:0] = TURN_BITS'(HALF_TURN + $urandom_range(0, 4) - 2);
			1: theta[TURN_BITS-1:0] = TURN_BITS'($urandom_range(0, 3));
			2: theta[TURN_BITS-1:0] = TURN_BITS'({TURN_BITS{1'b1}} - $urandom_range(0, 3));
			default: ;
		endcase
		queue_sample($urandom, theta);
	endfunction

	task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
			input logic [CFG_DATA_W-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Hold the sender until every queued request has produced its result
	task automatic wait_for_drain();
		do @(posedge clk); while (results_seen < reqs_queued);
	endtask

	// ------------------------------------------------------------------
	// Request driver: change inputs on the falling edge, hold a request until taken
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (!in_valid || req_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					in_valid <= 1'b0;
				end else if (pending_reqs.size() != 0) begin
					offered_req = pending_reqs.pop_front();
					in_valid <= 1'b1;
					mode <= offered_req.mode;
					grid_row <= offered_req.row;
					grid_col <= offered_req.col;
					grid_value <= offered_req.value;
					sample_phi <= offered_req.phi;
					sample_theta <= offered_req.theta;
					// Idle this long once the request is taken
					gap_left = $urandom_range(0, gap_max);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// ------------------------------------------------------------------
	// Result receiver: per-result stall, plus one long hold on request
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		if (arst_n) begin
			if (hold_order > 0) begin
				hold_left = hold_order;
				hold_order = 0;
			end
			if (res_taken)
				stall_left = $urandom_range(0, stall_max);
			if (hold_left > 0) begin
				hold_left--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// ------------------------------------------------------------------
	// Monitor: sample on the rising edge, check results, then predict new requests
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		req_taken <= in_valid && in_ready;
		res_taken <= out_valid && out_ready;
		if (arst_n) begin
			// Check before predicting so a same-edge request never pairs with this result
			if (out_valid && out_ready) begin
				results_seen <= results_seen + 1;
				if (expected_results.size() == 0) begin
					$error("unexpected result: sampled_value %0d, pole_crossed %0b, is_sample %0b",
						sampled_value, pole_crossed, is_sample);
					error_count++;
				end else begin
					oldest = expected_results.pop_front();
					if (sampled_value !== oldest.value) begin
						$error("sampled_value: expected %0d, got %0d", oldest.value, sampled_value);
						error_count++;
					end
					if (pole_crossed !== oldest.reflected) begin
						$error("pole_crossed: expected %0b, got %0b", oldest.reflected, pole_crossed);
						error_count++;
					end
					if (is_sample !== oldest.is_sample) begin
						$error("is_sample: expected %0b, got %0b", oldest.is_sample, is_sample);
						error_count++;
					end
					if (oldest.is_sample)
						samples_checked++;
					else
						writes_acked++;
					if (oldest.reflected)
						poles_seen++;
				end
			end
			if (in_valid && in_ready)
				expected_results.push_back(model_request(offered_req));
			if (cfg_valid && cfg_ready) begin
				config_writes++;
				case (cfg_index)
					REG_COLUMNS: columns_setting = cfg_data;
					REG_LAST_ROW: last_row_setting = cfg_data[CFG_ROWS_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// ------------------------------------------------------------------
	// Test sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n = 1'b0;
		in_valid = 1'b0;
		mode = MODE_WRITE;
		grid_row = '0;
		grid_col = '0;
		grid_value = '0;
		sample_phi = '0;
		sample_theta = '0;
		out_ready = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = REG_COLUMNS;
		cfg_data = '0;
		columns_setting = COLS_RESET;
		last_row_setting = ROWS_RESET;
		reqs_queued = 0;
		results_seen = 0;
		error_count = 0;
		samples_checked = 0;
		poles_seen = 0;
		writes_acked = 0;
		config_writes = 0;
		gap_max = IDLE_MAX;
		stall_max = IDLE_MAX;
		gap_left = 0;
		stall_left = 0;
		hold_order = 0;
		hold_left = 0;
		req_taken = 1'b0;
		res_taken = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed: a 4 x 3 grid small enough to fill completely
		write_register(REG_COLUMNS, 8'd4);
		write_register(REG_LAST_ROW, 8'd2);
		@(posedge clk);
		// Value extremes in the first corner cells
		queue_write(0, 0, 32'h8000_0000);
		queue_write(0, 1, 32'h7FFF_FFFF);
		for (int r = 0; r <= 2; r++)
			for (int c = 0; c < 4; c++)
				if (r != 0 || c > 1)
					queue_write(r, c, $urandom);
		// Address extremes: last legal cell, then rows past the grid (dropped)
		queue_write(GRID_LAST_ROW, GRID_COLUMNS - 1, 32'h7FFF_FFFF);
		queue_write(GRID_LAST_ROW + 1, 0, 32'h1234_5678);
		queue_write(127, 127, 32'hFFFF_FFFF);
		// Origin, both weights zero
		queue_sample(32'h0, 32'h0);
		// Exactly half a turn: no fold, upper row saturates
		queue_sample(32'h0001_0000, 32'h0008_0000);
		// Just past half a turn: folded
		queue_sample(32'h0001_0000, 32'h0008_0001);
		// Polar angle one unit short of a full turn
		queue_sample(32'h0000_0000, 32'h000F_FFFF);
		// Azimuth of -1 wraps to the last column and back to column 0
		queue_sample(32'hFFFF_FFFF, 32'h0003_FFFF);
		// Most negative angles
		queue_sample(32'h8000_0000, 32'h8000_0000);
		// Most positive angles: polar low bits all ones, so folded
		queue_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF);
		// Largest weights along both axes
		queue_sample(32'h0003_FFFF, 32'h0003_FFFF);
		// Half weight between rows 1 and 2
		queue_sample(32'h0002_0000, 32'h0006_0000);
		wait_for_drain();

		// Writes to spare indexes must change nothing
		write_register(REG_SPARE_LO, 8'hFF);
		write_register(REG_SPARE_HI, 8'h00);

		// Random phases; the sender pauses for a full drain before each register change
		for (int p = 0; p < PHASES; p++) begin
			wait_for_drain();
			write_register(REG_COLUMNS, CFG_DATA_W'(phase_cols[p]));
			write_register(REG_LAST_ROW, CFG_DATA_W'(phase_rows[p]));
			@(posedge clk);
			gap_max = phase_gap[p];
			stall_max = phase_stall[p];
			// Back-pressure: stall the output long enough to fill the block and
			// close its input while the sender keeps offering
			if (p == HOLD_PHASE)
				hold_order = HOLD_CYCLES;
			repeat (phase_count[p]) begin
				if ($urandom_range(0, 9) < 3)
					queue_random_write();
				else
					queue_random_sample();
			end
		end

		wait_for_drain();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (expected_results.size() != 0) begin
			$error("%0d results never arrived", expected_results.size());
			error_count++;
		end
		$display("Checked %0d interpolated samples (%0d folded past the south pole) and %0d %s",
			samples_checked, poles_seen, writes_acked, "write acknowledgements");
		$display("over %0d register writes, clamped settings included, with random idling %s",
			config_writes, "and one long output stall");
		if (error_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run
	initial begin
		#15_000_000;
		$display("Regression FAIL");
		$finish;
	end

endmodule

// ===== sim.f =====
sv/sgbs_pkg.sv
sv/sgbs_ram.sv
sv/sgbs_datapath.sv
sv/sgbs_ctrl.sv
sv/spherical_grid_bilinear_sampler_core.sv
bench/spherical_grid_bilinear_sampler_core_tb.sv
